>>> rtl/fpba_pkg.sv
package fpba_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_RESP
    } state_t;

    // shift/control command to every cell of a table; the table gates shift per cell
    typedef struct packed {
        logic clear;     // reinitialize table
        logic shift;     // cell k takes neighbor k+1, last cell goes invalid
        logic rotate;    // scan: cells pass contents toward the head, head wraps
    } cell_ctl_t;

endpackage

>>> rtl/fpba_cell.sv
module fpba_cell #(
    parameter int ADDR_BITS = 16
) (
    input  logic                  aclk,
    input  fpba_pkg::cell_ctl_t   ctl,
    input  logic                  clr_valid,
    input  logic [ADDR_BITS-1:0]  clr_base,
    input  logic [ADDR_BITS-1:0]  clr_len,
    input  logic                  wr_en,
    input  logic                  wr_valid,
    input  logic [ADDR_BITS-1:0]  wr_base,
    input  logic [ADDR_BITS-1:0]  wr_len,
    input  logic                  nb_valid,
    input  logic [ADDR_BITS-1:0]  nb_base,
    input  logic [ADDR_BITS-1:0]  nb_len,
    output logic                  valid,
    output logic [ADDR_BITS-1:0]  base,
    output logic [ADDR_BITS-1:0]  len
);

    logic                 valid_reg, valid_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [ADDR_BITS-1:0] len_reg, len_next;

    always_comb begin
        valid_next = valid_reg;
        base_next  = base_reg;
        len_next   = len_reg;
        priority if (ctl.clear) begin
            valid_next = clr_valid;
            base_next  = clr_base;
            len_next   = clr_len;
        end else if (wr_en) begin
            valid_next = wr_valid;
            base_next  = wr_base;
            len_next   = wr_len;
        end else if (ctl.shift || ctl.rotate) begin
            valid_next = nb_valid;
            base_next  = nb_base;
            len_next   = nb_len;
        end
    end

    always_ff @(posedge aclk) begin
        valid_reg <= valid_next;
        base_reg  <= base_next;
        len_reg   <= len_next;
    end

    assign valid = valid_reg;
    assign base  = base_reg;
    assign len   = len_reg;

endmodule

>>> rtl/fpba_table.sv
module fpba_table #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                  aclk,
    input  fpba_pkg::cell_ctl_t   ctl,
    input  logic [ADDR_BITS-1:0]  init_len,
    input  logic                  init_one,
    input  logic [$clog2(ENTRIES)-1:0] shift_from,
    input  logic                  wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_idx,
    input  logic                  wr_valid,
    input  logic [ADDR_BITS-1:0]  wr_base,
    input  logic [ADDR_BITS-1:0]  wr_len,
    output logic                  head_valid,
    output logic [ADDR_BITS-1:0]  head_base,
    output logic [ADDR_BITS-1:0]  head_len
);

    localparam int IW = $clog2(ENTRIES);

    logic                 v   [ENTRIES];
    logic [ADDR_BITS-1:0] b   [ENTRIES];
    logic [ADDR_BITS-1:0] l   [ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        localparam int NK = (k + 1) % ENTRIES;
        fpba_pkg::cell_ctl_t c;
        logic nv;
        always_comb begin
            c        = ctl;
            c.shift  = ctl.shift && (IW'(k) >= shift_from);
            nv       = (ctl.shift && k == ENTRIES - 1) ? 1'b0 : v[NK];
        end
        fpba_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
            .aclk      (aclk),
            .ctl       (c),
            .clr_valid ((k == 0) ? init_one : 1'b0),
            .clr_base  ('0),
            .clr_len   ((k == 0) ? init_len : '0),
            .wr_en     (wr_en && (wr_idx == IW'(k))),
            .wr_valid  (wr_valid),
            .wr_base   (wr_base),
            .wr_len    (wr_len),
            .nb_valid  (nv),
            .nb_base   (b[NK]),
            .nb_len    (l[NK]),
            .valid     (v[k]),
            .base      (b[k]),
            .len       (l[k])
        );
    end

    assign head_valid = v[0];
    assign head_base  = b[0];
    assign head_len   = l[0];

endmodule

>>> rtl/fit_policy_block_allocator.sv
// Channel   Dir  Payload
// s_axis    in   tdata: cmd, fit_policy, req_size, block_address
// m_axis    out  tdata: result_address, status
// cfg       in   pool_size write
// The block takes one item at a time, through SCAN, DECIDE, SHIFT and RESP: both
// tables rotate through their head cell together, one entry per cycle over the
// larger table, then the decide, shift and result states follow before idle;
// the result is registered in the shift state and shown in the result state.
// aresetn is synchronous; one clear cycle follows it and every pool_size write.
// A result holds on m_axis until taken; the next item waits for that.
module fit_policy_block_allocator #(
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // cmd[0], fit_policy[2:1], req_size[18:3], block_address[34:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // result_address[15:0], status[18:16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int UW = $clog2(USED_ENTRIES);
    localparam int NMAX = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
    localparam int CW = $clog2(NMAX + 1);

    fpba_pkg::state_t state_reg, state_next;

    logic                 cmd_reg;
    logic [1:0]           pol_reg;
    logic [ADDR_BITS-1:0] size_reg, addr_reg;
    logic [15:0]          pool_reg;
    logic                 init_pend_reg;

    logic [CW-1:0]        cnt_reg;
    logic [FW:0]          nf_reg;
    logic [UW:0]          nu_reg;
    logic                 found_reg;
    logic [FW-1:0]        fpick_reg;
    logic [ADDR_BITS-1:0] fpick_len_reg, fpick_base_reg;
    logic                 ufound_reg;
    logic [UW-1:0]        upick_reg;
    logic [ADDR_BITS-1:0] upick_len_reg;
    logic [15:0]          res_reg;
    fpba_pkg::status_t    st_reg;

    fpba_pkg::cell_ctl_t  fctl, uctl;
    logic                 fh_v, uh_v;
    logic [ADDR_BITS-1:0] fh_b, fh_l, uh_b, uh_l;
    logic                 fwr, uwr;
    logic [FW-1:0]        fwr_idx, fshift_from;
    logic [UW-1:0]        uwr_idx, ushift_from;
    logic                 fwr_v;
    logic [ADDR_BITS-1:0] fwr_b, fwr_l, uwr_b, uwr_l;
    logic [ADDR_BITS-1:0] init_len;

    logic s_acc, m_acc, c_acc, scanning;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign c_acc    = cfg_valid && cfg_ready;
    assign s_tready = (state_reg == fpba_pkg::S_IDLE) && !init_pend_reg;
    assign m_tvalid = (state_reg == fpba_pkg::S_RESP);
    assign cfg_ready = 1'b1;
    assign m_tdata  = {5'd0, st_reg, res_reg};
    assign scanning = (state_reg == fpba_pkg::S_SCAN);
    assign init_len = ADDR_BITS'(pool_reg);

    fpba_table #(.ENTRIES(FREE_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_free (
        .aclk(aclk), .ctl(fctl), .init_len(init_len), .init_one(init_len != '0),
        .shift_from(fshift_from), .wr_en(fwr), .wr_idx(fwr_idx), .wr_valid(fwr_v),
        .wr_base(fwr_b), .wr_len(fwr_l),
        .head_valid(fh_v), .head_base(fh_b), .head_len(fh_l));

    fpba_table #(.ENTRIES(USED_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_used (
        .aclk(aclk), .ctl(uctl), .init_len(init_len), .init_one(1'b0),
        .shift_from(ushift_from), .wr_en(uwr), .wr_idx(uwr_idx), .wr_valid(1'b1),
        .wr_base(uwr_b), .wr_len(uwr_l),
        .head_valid(uh_v), .head_base(uh_b), .head_len(uh_l));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fpba_pkg::S_IDLE:   if (s_acc) state_next = fpba_pkg::S_SCAN;
            fpba_pkg::S_SCAN:   if (cnt_reg == CW'(NMAX - 1)) state_next = fpba_pkg::S_DECIDE;
            fpba_pkg::S_DECIDE: state_next = fpba_pkg::S_SHIFT;
            fpba_pkg::S_SHIFT:  state_next = fpba_pkg::S_RESP;
            fpba_pkg::S_RESP:   if (m_acc) state_next = fpba_pkg::S_IDLE;
            default:            state_next = fpba_pkg::S_IDLE;
        endcase
    end

    // status from the final scan counts; it holds until the next item
    fpba_pkg::status_t st_calc;
    always_comb begin
        st_calc = fpba_pkg::ST_OK;
        if (cmd_reg == fpba_pkg::CMD_ALLOC) begin
            priority if (size_reg == '0) st_calc = fpba_pkg::ST_ZERO;
            else if (nu_reg >= (UW+1)'(USED_ENTRIES)) st_calc = fpba_pkg::ST_FULL;
            else if (!found_reg) st_calc = fpba_pkg::ST_NOFIT;
        end else begin
            priority if (!ufound_reg) st_calc = fpba_pkg::ST_NOTFOUND;
            else if (nf_reg >= (FW+1)'(FREE_ENTRIES)) st_calc = fpba_pkg::ST_FULL;
        end
    end

    logic alloc_ok, free_ok;
    assign alloc_ok = (cmd_reg == fpba_pkg::CMD_ALLOC) && (st_calc == fpba_pkg::ST_OK);
    assign free_ok  = (cmd_reg == fpba_pkg::CMD_FREE) && (st_calc == fpba_pkg::ST_OK);

    // table controls
    always_comb begin
        fctl = '0;
        uctl = '0;
        fctl.clear = init_pend_reg;
        uctl.clear = init_pend_reg;
        fctl.rotate = scanning && (cnt_reg < CW'(FREE_ENTRIES));
        uctl.rotate = scanning && (cnt_reg < CW'(USED_ENTRIES));
        fwr = 1'b0; fwr_idx = fpick_reg; fwr_v = 1'b1;
        fwr_b = fpick_base_reg + size_reg; fwr_l = fpick_len_reg - size_reg;
        uwr = 1'b0; uwr_idx = nu_reg[UW-1:0];
        uwr_b = fpick_base_reg; uwr_l = size_reg;
        fshift_from = fpick_reg;
        ushift_from = upick_reg;
        if (state_reg == fpba_pkg::S_DECIDE) begin
            if (alloc_ok) begin
                uwr = 1'b1;
                fwr = (fpick_len_reg != size_reg);
            end else if (free_ok) begin
                fwr     = 1'b1;
                fwr_idx = nf_reg[FW-1:0];
                fwr_b   = addr_reg;
                fwr_l   = upick_len_reg;
            end
        end
        if (state_reg == fpba_pkg::S_SHIFT) begin
            fctl.shift = alloc_ok && (fpick_len_reg == size_reg);
            uctl.shift = free_ok;
        end
    end

    logic [FW-1:0] fidx;
    logic [UW-1:0] uidx;
    logic better;
    assign fidx = cnt_reg[FW-1:0];
    assign uidx = cnt_reg[UW-1:0];

    always_comb begin
        better = 1'b0;
        if (fh_v && fh_l >= size_reg) begin
            if (!found_reg) better = 1'b1;
            else if (pol_reg == fpba_pkg::POL_BEST) better = fh_l < fpick_len_reg;
            else if (pol_reg == fpba_pkg::POL_WORST) better = fh_l > fpick_len_reg;
        end
        if (pol_reg == 2'd3) better = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fpba_pkg::S_IDLE;
            pool_reg      <= 16'hFFFF;
            init_pend_reg <= 1'b1;
        end else begin
            state_reg     <= state_next;
            init_pend_reg <= c_acc;
            if (c_acc) pool_reg <= cfg_data;
        end
        if (s_acc) begin
            cmd_reg   <= s_tdata[0];
            pol_reg   <= s_tdata[2:1];
            size_reg  <= ADDR_BITS'(s_tdata[18:3]);
            addr_reg  <= ADDR_BITS'(s_tdata[34:19]);
            cnt_reg   <= '0;
            nf_reg    <= '0;
            nu_reg    <= '0;
            found_reg <= 1'b0;
            ufound_reg <= 1'b0;
            fpick_reg <= '0;
            upick_reg <= '0;
        end
        if (scanning) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg < CW'(FREE_ENTRIES)) begin
                if (fh_v) nf_reg <= nf_reg + 1'b1;
                if (better) begin
                    found_reg      <= 1'b1;
                    fpick_reg      <= fidx;
                    fpick_len_reg  <= fh_l;
                    fpick_base_reg <= fh_b;
                end
            end
            if (cnt_reg < CW'(USED_ENTRIES)) begin
                if (uh_v) nu_reg <= nu_reg + 1'b1;
                if (uh_v && !ufound_reg && uh_b == addr_reg) begin
                    ufound_reg    <= 1'b1;
                    upick_reg     <= uidx;
                    upick_len_reg <= uh_l;
                end
            end
        end
    end

    // first-fit keeps the first hit; later hits never pass 'better'
    // because found_reg holds and policy first keeps the pick.
    always_ff @(posedge aclk) begin
        if (state_reg == fpba_pkg::S_SHIFT) begin
            res_reg <= alloc_ok ? 16'(fpick_base_reg) : 16'd0;
        end
    end

    // capture the status for the result
    always_ff @(posedge aclk) begin
        if (state_reg == fpba_pkg::S_DECIDE)
            st_reg <= st_calc;
    end

`ifndef SYNTH
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("item accepted while result pending");
    a_zero_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg != fpba_pkg::ST_OK |-> res_reg == 16'd0)
        else $error("failure returned nonzero address");
`endif

endmodule
